>>> sv/wasb_pkg.sv
// Package: shared types and constants for the windowed abuse score ban block
`timescale 1ns / 1ps
package wasb_pkg;
    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_ADD  = 2'd1;
    localparam logic [1:0] REQ_BAN  = 2'd2;
    localparam logic [1:0] REQ_RSVD = 2'd3;   // no operation, result only
    localparam logic [15:0] BAN_FLOOR_RESET = 16'd1200;

    // buckets per window; a power of two so slot and score are bit selects
    localparam int WINDOW_SECONDS = 16;

    typedef enum logic [3:0] {
        S_IDLE, S_TICK, S_ADD_CHK, S_ZERO, S_ADDAMT, S_SUM, S_MUL1, S_MUL2,
        S_BANSET, S_FLUSH, S_RESULT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture input beat
        logic tick;
        logic add_chk;    // overrun check / restart
        logic zero_step;  // one lazy-zero step
        logic add_amt;
        logic sum_start;
        logic sum_step;
        logic mul1;
        logic mul2;
        logic ban_set;
        logic flush_step;
        logic result;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic zero_done;
        logic sum_done;
        logic flush_done;
    } t_sts;
endpackage

>>> sv/wasb_if.sv
// Interfaces: valid/ready channels for input and result beats
`timescale 1ns / 1ps
interface wasb_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic        which_score;
    logic [31:0] amount;
    modport source (output valid, req_type, which_score, amount, input ready);
    modport sink (input valid, req_type, which_score, amount, output ready);
    modport monitor (input valid, ready, req_type, which_score, amount);
endinterface

interface wasb_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] request_score;
    logic [31:0] connection_score;
    logic        banned;
    logic [31:0] total_bans;
    logic [31:0] last_penalty;
    modport source (output valid, request_score, connection_score, banned,
                    total_bans, last_penalty, input ready);
    modport sink (input valid, request_score, connection_score, banned,
                  total_bans, last_penalty, output ready);
    modport monitor (input valid, ready, request_score, connection_score, banned,
                     total_bans, last_penalty);
endinterface

>>> sv/wasb_ctrl.sv
// Controller: sequences one beat through the datapath
`timescale 1ns / 1ps
module wasb_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic [1:0]     i_req_type,
    input  logic           i_out_busy,
    input  wasb_pkg::t_sts i_sts,
    output logic           o_in_ready,
    output wasb_pkg::t_cmd o_cmd
);
    wasb_pkg::t_state r_state, n_state;
    // remembered beat kind
    logic [1:0] r_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wasb_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            wasb_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    case (i_req_type)
                        wasb_pkg::REQ_TICK: n_state = wasb_pkg::S_TICK;
                        wasb_pkg::REQ_ADD:  n_state = wasb_pkg::S_ADD_CHK;
                        wasb_pkg::REQ_BAN:  n_state = wasb_pkg::S_SUM;
                        default:            n_state = wasb_pkg::S_RESULT;
                    endcase
                end
            end
            wasb_pkg::S_TICK:    n_state = wasb_pkg::S_RESULT;
            wasb_pkg::S_ADD_CHK: n_state = wasb_pkg::S_ZERO;
            wasb_pkg::S_ZERO: begin
                if (i_sts.zero_done) n_state = wasb_pkg::S_ADDAMT;
            end
            wasb_pkg::S_ADDAMT:  n_state = wasb_pkg::S_SUM;
            wasb_pkg::S_SUM: begin
                if (i_sts.sum_done) begin
                    n_state = (r_kind == wasb_pkg::REQ_BAN) ?
                              wasb_pkg::S_MUL1 : wasb_pkg::S_RESULT;
                end
            end
            wasb_pkg::S_MUL1:    n_state = wasb_pkg::S_MUL2;
            wasb_pkg::S_MUL2:    n_state = wasb_pkg::S_BANSET;
            wasb_pkg::S_BANSET:  n_state = wasb_pkg::S_FLUSH;
            wasb_pkg::S_FLUSH: begin
                if (i_sts.flush_done) n_state = wasb_pkg::S_RESULT;
            end
            wasb_pkg::S_RESULT: begin
                if (!i_out_busy) n_state = wasb_pkg::S_IDLE;
            end
            default: n_state = wasb_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == wasb_pkg::S_IDLE && i_in_valid) r_kind <= i_req_type;
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            wasb_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
                o_cmd.sum_start = i_in_valid;
            end
            wasb_pkg::S_TICK:    o_cmd.tick = 1'b1;
            wasb_pkg::S_ADD_CHK: o_cmd.add_chk = 1'b1;
            wasb_pkg::S_ZERO:    o_cmd.zero_step = 1'b1;
            wasb_pkg::S_ADDAMT: begin
                o_cmd.add_amt = 1'b1;
                o_cmd.sum_start = 1'b1;
            end
            wasb_pkg::S_SUM:     o_cmd.sum_step = 1'b1;
            wasb_pkg::S_MUL1:    o_cmd.mul1 = 1'b1;
            wasb_pkg::S_MUL2:    o_cmd.mul2 = 1'b1;
            wasb_pkg::S_BANSET:  o_cmd.ban_set = 1'b1;
            wasb_pkg::S_FLUSH:   o_cmd.flush_step = 1'b1;
            wasb_pkg::S_RESULT:  o_cmd.result = !i_out_busy;
            default: ;
        endcase
    end

    property p_ready_idle;
        @(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_state == wasb_pkg::S_IDLE);
    endproperty
    a_ready_idle: assert property (p_ready_idle) else $error("ready outside idle");

    property p_result_then_idle;
        @(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.result |=> (r_state == wasb_pkg::S_IDLE);
    endproperty
    a_result_idle: assert property (p_result_then_idle) else $error("no idle after result");

    property p_load_leaves_idle;
        @(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state != wasb_pkg::S_IDLE);
    endproperty
    a_load: assert property (p_load_leaves_idle) else $error("load stayed idle");
endmodule

>>> sv/wasb_dp.sv
// Datapath: bucket rings, counters, score summing and ban arithmetic
`timescale 1ns / 1ps
module wasb_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  wasb_pkg::t_cmd i_cmd,
    input  logic           i_which_score,
    input  logic [31:0]    i_amount,
    input  logic [15:0]    i_ban_floor,
    output wasb_pkg::t_sts o_sts,
    output logic [31:0]    o_request_score,
    output logic [31:0]    o_connection_score,
    output logic           o_banned,
    output logic [31:0]    o_total_bans,
    output logic [31:0]    o_last_penalty
);
    localparam int WINDOW_SECONDS = wasb_pkg::WINDOW_SECONDS;
    localparam int IW = (WINDOW_SECONDS > 1) ? $clog2(WINDOW_SECONDS) : 1;
    localparam int CW = $clog2(WINDOW_SECONDS + 1);
    localparam logic [31:0] WIN32 = 32'(WINDOW_SECONDS);
    localparam logic [CW-1:0] WINC = CW'(WINDOW_SECONDS);

    // bucket memories, one per score; index 0 request, 1 connection
    logic [31:0] r_mem_r [WINDOW_SECONDS];
    logic [31:0] r_mem_c [WINDOW_SECONDS];
    // used flags and validity (an invalid entry reads as zero)
    logic [WINDOW_SECONDS-1:0] r_used_r, r_used_c, r_vld_r, r_vld_c;
    logic [31:0] r_sec_r, r_sec_c;
    logic [IW-1:0] r_pos_r, r_pos_c;
    logic [31:0] r_ban_count, r_ban_rem, r_penalty;
    logic        r_which;
    logic [31:0] r_amount;
    logic [IW-1:0] r_slot;
    logic [CW-1:0] r_idx;
    logic [31:0] r_sum_r, r_sum_c;
    logic [31:0] r_score_r, r_score_c;
    logic [31:0] r_prod, r_by_floor;

    // selected window view
    logic [31:0] sec_sel;
    logic [IW-1:0] pos_sel;
    logic [IW-1:0] idx_w;
    assign sec_sel = r_which ? r_sec_c : r_sec_r;
    assign pos_sel = r_which ? r_pos_c : r_pos_r;
    assign idx_w   = r_idx[IW-1:0];

    // slot of old seconds modulo window; the window is a power of two,
    // so this is the low bits of the seconds count
    logic [31:0] sec_mod;
    assign sec_mod = sec_sel % WIN32;

    // bucket values as read (invalid reads zero)
    logic [31:0] rd_r, rd_c;
    assign rd_r = r_vld_r[idx_w] ? r_mem_r[idx_w] : 32'd0;
    assign rd_c = r_vld_c[idx_w] ? r_mem_c[idx_w] : 32'd0;

    logic zero_end, sum_end, flush_end;
    assign zero_end  = (r_idx > {1'b0, r_slot}) || (r_idx == WINC);
    assign sum_end   = (r_idx == WINC);
    assign flush_end = 1'b1;
    assign o_sts.zero_done  = zero_end;
    assign o_sts.sum_done   = sum_end;
    assign o_sts.flush_done = flush_end;

    // control-side state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_r <= '0; r_vld_c <= '0;
            r_used_r <= '1; r_used_c <= '1;
            r_sec_r <= '0; r_sec_c <= '0;
            r_pos_r <= '0; r_pos_c <= '0;
            r_ban_count <= '0; r_ban_rem <= '0; r_penalty <= '0;
            r_score_r <= '0; r_score_c <= '0;
        end else begin
            if (i_cmd.tick) begin
                if (r_sec_r != '1) r_sec_r <= r_sec_r + 32'd1;
                if (r_sec_c != '1) r_sec_c <= r_sec_c + 32'd1;
                if (r_ban_rem != '0) r_ban_rem <= r_ban_rem - 32'd1;
            end
            if (i_cmd.add_chk && sec_sel >= WIN32) begin
                if (r_which) begin
                    r_used_c <= '0; r_sec_c <= '0; r_pos_c <= '0;
                end else begin
                    r_used_r <= '0; r_sec_r <= '0; r_pos_r <= '0;
                end
            end
            // lazy zero: one slot per cycle
            if (i_cmd.zero_step && !zero_end) begin
                if (r_which) begin
                    if (!r_used_c[idx_w]) begin
                        r_used_c[idx_w] <= 1'b1; r_vld_c[idx_w] <= 1'b0;
                    end
                end else begin
                    if (!r_used_r[idx_w]) begin
                        r_used_r[idx_w] <= 1'b1; r_vld_r[idx_w] <= 1'b0;
                    end
                end
            end
            if (i_cmd.add_amt) begin
                if (r_which) begin
                    r_vld_c[r_slot] <= 1'b1; r_pos_c <= r_slot;
                end else begin
                    r_vld_r[r_slot] <= 1'b1; r_pos_r <= r_slot;
                end
            end
            if (i_cmd.sum_step && sum_end) begin
                r_score_r <= r_sum_r / WIN32;
                r_score_c <= r_sum_c / WIN32;
            end
            if (i_cmd.load) r_ban_count <= r_ban_count;
            if (i_cmd.ban_set) begin
                r_ban_rem <= (r_prod > r_by_floor) ? r_prod : r_by_floor;
                r_penalty <= (r_prod > r_by_floor) ? r_prod : r_by_floor;
            end
            if (i_cmd.mul1) r_ban_count <= r_ban_count + 32'd1;
            if (i_cmd.flush_step) begin
                r_vld_r <= '0; r_vld_c <= '0;
                r_used_r <= '0; r_used_c <= '0;
                r_sec_r <= '0; r_sec_c <= '0;
                r_pos_r <= '0; r_pos_c <= '0;
                r_score_r <= '0; r_score_c <= '0;
            end
        end
    end

    // current value of the slot being added to
    logic [31:0] rd_slot;
    assign rd_slot = r_which ? (r_vld_c[r_slot] ? r_mem_c[r_slot] : 32'd0)
                             : (r_vld_r[r_slot] ? r_mem_r[r_slot] : 32'd0);

    // bucket memory writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.add_amt) begin
            if (r_which) r_mem_c[r_slot] <= rd_slot + r_amount;
            else         r_mem_r[r_slot] <= rd_slot + r_amount;
        end
    end

    // beat capture, walk index, sums, products
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_which  <= i_which_score;
            r_amount <= i_amount;
        end
        if (i_cmd.add_chk) begin
            r_slot <= sec_mod[IW-1:0];
            r_idx  <= (sec_sel >= WIN32) ? '0 : {1'b0, pos_sel};
        end
        if (i_cmd.zero_step) r_idx <= r_idx + CW'(1);
        if (i_cmd.sum_start) begin
            r_idx <= '0; r_sum_r <= '0; r_sum_c <= '0;
        end
        if (i_cmd.sum_step && !sum_end) begin
            r_sum_r <= r_sum_r + rd_r;
            r_sum_c <= r_sum_c + rd_c;
            r_idx   <= r_idx + CW'(1);
        end
        // ban count is incremented in mul1; use +1 here
        if (i_cmd.mul1) begin
            r_prod     <= (r_ban_count + 32'd1) * (r_score_r + 32'd1);
            r_by_floor <= (r_ban_count + 32'd1) * {16'd0, i_ban_floor};
        end
        if (i_cmd.mul2) r_prod <= r_prod * (r_score_c + 32'd1);
    end

    assign o_request_score    = r_score_r;
    assign o_connection_score = r_score_c;
    assign o_banned           = (r_ban_rem != '0);
    assign o_total_bans       = r_ban_count;
    assign o_last_penalty     = r_penalty;

    property p_flush_clears;
        @(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.flush_step |=> (r_score_r == '0 && r_score_c == '0);
    endproperty
    a_flush: assert property (p_flush_clears) else $error("flush left score");

    property p_ban_counts;
        @(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mul1 |=> (r_ban_count == $past(r_ban_count) + 32'd1);
    endproperty
    a_ban: assert property (p_ban_counts) else $error("ban count slip");

    property p_pos_in_range;
        @(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.add_amt |=> (r_which ? r_pos_c == r_slot : r_pos_r == r_slot);
    endproperty
    a_pos: assert property (p_pos_in_range) else $error("position not updated");
endmodule

>>> sv/windowed_abuse_score_ban.sv
// Top level: windowed abuse score with ban countdown
// From the accepting cycle: tick passes its tick state to the result; add runs
// the overrun check, the lazy-zero walk, the add, then the summing walk; ban
// runs the summing walk, both multiplies, the ban set and the flush. One beat
// in flight; the next beat is taken the cycle after the result register loads.
// Reset: synchronous active low; all buckets read zero and flagged used,
// counters zero, floor register 1200. No clearing pass.
`timescale 1ns / 1ps
module windowed_abuse_score_ban (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    wasb_in_if.sink     i_in,
    wasb_out_if.source  o_out
);
    wasb_pkg::t_cmd cmd;
    wasb_pkg::t_sts sts;
    logic [15:0] r_floor;
    logic        r_out_valid;
    logic [31:0] rs, cs, tb, lp;
    logic        bn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor <= wasb_pkg::BAN_FLOOR_RESET;
        end else if (i_cfg_we) begin
            r_floor <= i_cfg_wdata;
        end
    end

    wasb_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid (i_in.valid),
        .i_req_type (i_in.req_type),
        .i_out_busy (r_out_valid && !o_out.ready),
        .i_sts      (sts),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd)
    );

    wasb_dp u_dp (
        .i_clk, .i_rst_n,
        .i_cmd (cmd),
        .i_which_score (i_in.which_score),
        .i_amount (i_in.amount),
        .i_ban_floor (r_floor),
        .o_sts (sts),
        .o_request_score (rs), .o_connection_score (cs),
        .o_banned (bn), .o_total_bans (tb), .o_last_penalty (lp)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.result) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (cmd.result) begin
            o_out.request_score    <= rs;
            o_out.connection_score <= cs;
            o_out.banned           <= bn;
            o_out.total_bans       <= tb;
            o_out.last_penalty     <= lp;
        end
    end
    assign o_out.valid = r_out_valid;
endmodule
